### hw/rtl/gdg_pkg.sv
// Shared constants, types and state codes for the Gauss diagram face tracer.
package gdg_pkg;

  localparam int MAX_CODE_LENGTH = 64;
  localparam int MAX_CROSSINGS   = 32;
  localparam int ID_W            = 5;
  localparam int SM_W            = 2;
  localparam int ELEM_W          = ID_W + SM_W;
  localparam int LEN_W           = $clog2(MAX_CODE_LENGTH + 1);
  localparam int PIDX_W          = $clog2(MAX_CODE_LENGTH);
  localparam int EIDX_W          = PIDX_W + 1;
  localparam int EDGE_CAP        = 2 * MAX_CODE_LENGTH;
  localparam int KEY_W           = 2 * ELEM_W + 1;
  localparam int PAIR_W          = 2 * ELEM_W;
  localparam int VERT_W          = LEN_W - 1;
  localparam int GEN_W           = 6;
  localparam int FACE_W          = 8;
  localparam int FIFO_DEPTH      = 4;
  localparam int FIFO_AW         = $clog2(FIFO_DEPTH);

  // Shifted sign of a vertex: under -1, over, under +1.
  localparam logic [SM_W-1:0] SM_NEG  = 2'd0;
  localparam logic [SM_W-1:0] SM_OVER = 2'd1;
  localparam logic [SM_W-1:0] SM_POS  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [SM_W-1:0] sm;
  } elem_t;

  typedef struct packed {
    elem_t hi;
    elem_t lo;
  } pair_t;

  typedef enum logic {
    CMD_PAIR,
    CMD_CLOSE
  } cmd_kind_t;

  // PAIR: len holds the pair index, a/b the two elements.
  // CLOSE: len holds the code length, a/b/c are previous, current and first element.
  typedef struct packed {
    cmd_kind_t        kind;
    logic             err;
    logic [LEN_W-1:0] len;
    elem_t            a;
    elem_t            b;
    elem_t            c;
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CA,
    S_CB,
    S_DK,
    S_DK2,
    S_DJ,
    S_DJ2,
    S_DFIN,
    S_MK,
    S_MK2,
    S_WK,
    S_WK2,
    S_WHIT,
    S_DONE
  } state_t;

endpackage

### hw/rtl/gdg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gdg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/gdg_fifo.sv
// Short command queue between the loading front end and the tracing back end.
module gdg_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gdg_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output gdg_pkg::cmd_t pop_data,
  output logic          empty
);

  gdg_pkg::cmd_t                 mem [gdg_pkg::FIFO_DEPTH];
  logic [gdg_pkg::FIFO_AW-1:0]   wptr;
  logic [gdg_pkg::FIFO_AW-1:0]   rptr;
  logic [gdg_pkg::FIFO_AW:0]     count;

  assign full     = (count == (gdg_pkg::FIFO_AW+1)'(gdg_pkg::FIFO_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (pop && !empty) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + ((push && !full) ? 1'b1 : 1'b0) - ((pop && !empty) ? 1'b1 : 1'b0);
    end
  end

endmodule

### hw/rtl/gdg_front.sv
// Front end: accepts code elements, checks ranges and issues pair and close commands.
module gdg_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [gdg_pkg::ID_W-1:0]   crossing_id,
  input  logic                       is_over,
  input  logic                       crossing_sign,
  input  logic                       last,
  output logic                       push,
  output gdg_pkg::cmd_t              cmd,
  input  logic                       full
);

  logic [gdg_pkg::LEN_W-1:0] count;
  logic [gdg_pkg::LEN_W-1:0] count_next;
  gdg_pkg::elem_t            prev;
  gdg_pkg::elem_t            first;
  logic [gdg_pkg::ID_W-1:0]  max_id;
  logic [gdg_pkg::ID_W-1:0]  max_id_next;
  logic                      overflow;
  logic                      overflow_next;
  logic                      accept;
  logic                      room;
  gdg_pkg::elem_t            elem;
  logic [gdg_pkg::LEN_W-1:0] len_v;
  logic [gdg_pkg::ID_W-1:0]  max_v;

  assign item_stall = full;
  assign accept     = item_valid && !full;
  assign room       = (count < gdg_pkg::LEN_W'(gdg_pkg::MAX_CODE_LENGTH));

  always_comb begin
    elem.id = crossing_id;
    if (is_over) begin
      elem.sm = gdg_pkg::SM_OVER;
    end else if (crossing_sign) begin
      elem.sm = gdg_pkg::SM_NEG;
    end else begin
      elem.sm = gdg_pkg::SM_POS;
    end
    len_v = room ? count + 1'b1 : count;
    max_v = (room && crossing_id > max_id) ? crossing_id : max_id;

    push     = accept && (last || (room && count != '0));
    cmd.kind = last ? gdg_pkg::CMD_CLOSE : gdg_pkg::CMD_PAIR;
    cmd.err  = overflow || !room || ({1'b0, max_v} >= len_v[gdg_pkg::LEN_W-1:1]);
    cmd.len  = last ? len_v : count - 1'b1;
    cmd.a    = prev;
    cmd.b    = elem;
    cmd.c    = first;

    count_next    = count;
    max_id_next   = max_id;
    overflow_next = overflow;
    if (accept) begin
      if (last) begin
        count_next    = '0;
        max_id_next   = '0;
        overflow_next = 1'b0;
      end else begin
        count_next    = len_v;
        max_id_next   = max_v;
        overflow_next = overflow || !room;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && room) begin
      prev <= elem;
      if (count == '0) begin
        first <= elem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      max_id   <= '0;
      overflow <= 1'b0;
    end else begin
      count    <= count_next;
      max_id   <= max_id_next;
      overflow <= overflow_next;
    end
  end

endmodule

### hw/rtl/gdg_back.sv
// Back end: builds the edge set, removes duplicates, traces faces and forms the result.
module gdg_back (
  input  logic                         clk,
  input  logic                         rst,
  input  gdg_pkg::cmd_t                head,
  input  logic                         fifo_empty,
  output logic                         pop,
  output logic                         result_valid,
  input  logic                         result_stall,
  output logic [gdg_pkg::GEN_W-1:0]    genus_value,
  output logic [gdg_pkg::FACE_W-1:0]   face_count,
  output logic                         error_flag
);

  gdg_pkg::state_t              state;
  gdg_pkg::state_t              state_next;
  logic [gdg_pkg::LEN_W-1:0]    len;
  logic [gdg_pkg::LEN_W-1:0]    len_next;
  logic                         err;
  logic                         err_next;
  gdg_pkg::elem_t               cprev;
  gdg_pkg::elem_t               cprev_next;
  gdg_pkg::elem_t               ccur;
  gdg_pkg::elem_t               ccur_next;
  gdg_pkg::elem_t               cfirst;
  gdg_pkg::elem_t               cfirst_next;
  logic [gdg_pkg::PIDX_W-1:0]   k;
  logic [gdg_pkg::PIDX_W-1:0]   k_next;
  logic [gdg_pkg::PIDX_W-1:0]   j;
  logic [gdg_pkg::PIDX_W-1:0]   j_next;
  logic                         dup;
  logic                         dup_next;
  gdg_pkg::pair_t               pk;
  gdg_pkg::pair_t               pk_next;
  logic [gdg_pkg::EDGE_CAP-1:0] free;
  logic                         found;
  logic                         found_next;
  logic [gdg_pkg::KEY_W-1:0]    best_key;
  logic [gdg_pkg::KEY_W-1:0]    best_key_next;
  logic [gdg_pkg::EIDX_W-1:0]   best_idx;
  logic [gdg_pkg::EIDX_W-1:0]   best_idx_next;
  gdg_pkg::pair_t               best_pair;
  gdg_pkg::pair_t               best_pair_next;
  logic [gdg_pkg::EIDX_W-1:0]   start_idx;
  logic [gdg_pkg::EIDX_W-1:0]   start_idx_next;
  logic [gdg_pkg::EIDX_W-1:0]   cur_idx;
  logic [gdg_pkg::EIDX_W-1:0]   cur_idx_next;
  gdg_pkg::pair_t               cur_pair;
  gdg_pkg::pair_t               cur_pair_next;
  logic [gdg_pkg::EIDX_W-1:0]   nxt_idx;
  logic [gdg_pkg::EIDX_W-1:0]   nxt_idx_next;
  gdg_pkg::pair_t               nxt_pair;
  gdg_pkg::pair_t               nxt_pair_next;
  logic [gdg_pkg::FACE_W-1:0]   faces;
  logic [gdg_pkg::FACE_W-1:0]   faces_next;
  logic                         free_set;
  logic                         free_clr;
  logic                         load_out;

  logic                         ram_we;
  logic [gdg_pkg::PIDX_W-1:0]   ram_waddr;
  gdg_pkg::pair_t               ram_wdata;
  logic [gdg_pkg::PIDX_W-1:0]   ram_raddr;
  gdg_pkg::pair_t               rdata;

  logic                         k_last;
  logic [gdg_pkg::LEN_W-1:0]    len_m1;
  logic [gdg_pkg::LEN_W-1:0]    len_m2;
  logic [gdg_pkg::KEY_W-1:0]    key_fw;
  logic [gdg_pkg::KEY_W-1:0]    key_rv;
  logic                         take_fw;
  logic                         take_rv;
  logic                         mid_found;
  logic [gdg_pkg::KEY_W-1:0]    mid_key;
  gdg_pkg::elem_t               hv;
  logic                         cur_d;
  logic                         same;
  logic                         fw_m;
  logic                         rv_m;
  logic [gdg_pkg::EIDX_W-1:0]   fw_idx;
  logic [gdg_pkg::EIDX_W-1:0]   rv_idx;
  logic [gdg_pkg::FACE_W:0]     excess;
  logic [gdg_pkg::FACE_W:0]     faces_w;
  logic [gdg_pkg::GEN_W-1:0]    genus_v;

  gdg_ram #(
    .WIDTH(gdg_pkg::PAIR_W),
    .DEPTH(gdg_pkg::MAX_CODE_LENGTH)
  ) u_pair_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(rdata)
  );

  assign k_last = ({1'b0, k} + 1'b1 == len);
  assign len_m1 = len - 1'b1;
  assign len_m2 = len - 2'd2;
  assign fw_idx = {k, 1'b0};
  assign rv_idx = {k, 1'b1};

  // Keys order edges by (from, to, direction); the packed element order matches.
  assign key_fw = {rdata.hi, rdata.lo, 1'b1};
  assign key_rv = {rdata.lo, rdata.hi, 1'b0};

  always_comb begin
    take_fw   = free[fw_idx] && (!found || key_fw < best_key);
    mid_found = found || take_fw;
    mid_key   = take_fw ? key_fw : best_key;
    take_rv   = free[rv_idx] && (!mid_found || key_rv < mid_key);
  end

  // Turn rule at the head vertex of the current edge.
  always_comb begin
    cur_d = cur_idx[0];
    hv    = cur_d ? cur_pair.hi : cur_pair.lo;
    same  = ((hv.sm == gdg_pkg::SM_POS) == cur_d);
    if (hv.sm == gdg_pkg::SM_OVER) begin
      fw_m = (rdata.hi.id == hv.id) &&
             (rdata.hi.sm == (cur_d ? gdg_pkg::SM_NEG : gdg_pkg::SM_POS));
      rv_m = (rdata.lo.id == hv.id) &&
             (rdata.lo.sm == (cur_d ? gdg_pkg::SM_POS : gdg_pkg::SM_NEG));
    end else begin
      fw_m = (rdata.hi.id == hv.id) && (rdata.hi.sm == gdg_pkg::SM_OVER) && same;
      rv_m = (rdata.lo.id == hv.id) && (rdata.lo.sm == gdg_pkg::SM_OVER) && !same;
    end
  end

  always_comb begin
    faces_w = {1'b0, faces};
    excess  = (gdg_pkg::FACE_W+1)'(len[gdg_pkg::LEN_W-1:1]) + 2'd2;
    if (!err && faces_w <= excess) begin
      genus_v = gdg_pkg::GEN_W'((excess - faces_w) >> 1);
    end else begin
      genus_v = '0;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gdg_pkg::S_IDLE: begin
        if (!fifo_empty && head.kind == gdg_pkg::CMD_CLOSE) begin
          state_next = head.err ? gdg_pkg::S_DONE : gdg_pkg::S_CA;
        end
      end
      gdg_pkg::S_CA:  state_next = gdg_pkg::S_CB;
      gdg_pkg::S_CB:  state_next = gdg_pkg::S_DK;
      gdg_pkg::S_DK:  state_next = gdg_pkg::S_DK2;
      gdg_pkg::S_DK2: state_next = (k == '0) ? gdg_pkg::S_DFIN : gdg_pkg::S_DJ;
      gdg_pkg::S_DJ:  state_next = gdg_pkg::S_DJ2;
      gdg_pkg::S_DJ2: state_next = (j + 1'b1 == k) ? gdg_pkg::S_DFIN : gdg_pkg::S_DJ;
      gdg_pkg::S_DFIN: state_next = k_last ? gdg_pkg::S_MK : gdg_pkg::S_DK;
      gdg_pkg::S_MK:  state_next = gdg_pkg::S_MK2;
      gdg_pkg::S_MK2: begin
        if (!k_last) begin
          state_next = gdg_pkg::S_MK;
        end else if (mid_found || take_rv) begin
          state_next = gdg_pkg::S_WK;
        end else begin
          state_next = gdg_pkg::S_DONE;
        end
      end
      gdg_pkg::S_WK:  state_next = gdg_pkg::S_WK2;
      gdg_pkg::S_WK2: begin
        state_next = (fw_m || rv_m || k_last) ? gdg_pkg::S_WHIT : gdg_pkg::S_WK;
      end
      gdg_pkg::S_WHIT: begin
        if (!free[nxt_idx]) begin
          state_next = gdg_pkg::S_DONE;
        end else if (nxt_idx == start_idx) begin
          state_next = gdg_pkg::S_MK;
        end else begin
          state_next = gdg_pkg::S_WK;
        end
      end
      gdg_pkg::S_DONE: begin
        if (!result_valid || !result_stall) begin
          state_next = gdg_pkg::S_IDLE;
        end
      end
      default: state_next = gdg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    len_next       = len;
    err_next       = err;
    cprev_next     = cprev;
    ccur_next      = ccur;
    cfirst_next    = cfirst;
    k_next         = k;
    j_next         = j;
    dup_next       = dup;
    pk_next        = pk;
    found_next     = found;
    best_key_next  = best_key;
    best_idx_next  = best_idx;
    best_pair_next = best_pair;
    start_idx_next = start_idx;
    cur_idx_next   = cur_idx;
    cur_pair_next  = cur_pair;
    nxt_idx_next   = nxt_idx;
    nxt_pair_next  = nxt_pair;
    faces_next     = faces;
    free_set       = 1'b0;
    free_clr       = 1'b0;
    load_out       = 1'b0;
    pop            = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = k;
    ram_wdata      = {cprev, ccur};
    ram_raddr      = k;
    unique case (state)
      gdg_pkg::S_IDLE: begin
        if (!fifo_empty) begin
          pop = 1'b1;
          if (head.kind == gdg_pkg::CMD_PAIR) begin
            ram_we    = 1'b1;
            ram_waddr = head.len[gdg_pkg::PIDX_W-1:0];
            ram_wdata = {head.a, head.b};
          end else begin
            len_next    = head.len;
            err_next    = head.err;
            cprev_next  = head.a;
            ccur_next   = head.b;
            cfirst_next = head.c;
            faces_next  = '0;
            k_next      = '0;
          end
        end
      end
      gdg_pkg::S_CA: begin
        ram_we    = 1'b1;
        ram_waddr = len_m2[gdg_pkg::PIDX_W-1:0];
        ram_wdata = {cprev, ccur};
      end
      gdg_pkg::S_CB: begin
        // Closing pair wraps from the last element back to the first.
        ram_we    = 1'b1;
        ram_waddr = len_m1[gdg_pkg::PIDX_W-1:0];
        ram_wdata = {ccur, cfirst};
        k_next    = '0;
      end
      gdg_pkg::S_DK: begin
        ram_raddr = k;
      end
      gdg_pkg::S_DK2: begin
        pk_next  = rdata;
        dup_next = 1'b0;
        j_next   = '0;
      end
      gdg_pkg::S_DJ: begin
        ram_raddr = j;
      end
      gdg_pkg::S_DJ2: begin
        if (rdata == pk) begin
          dup_next = 1'b1;
        end
        j_next = j + 1'b1;
      end
      gdg_pkg::S_DFIN: begin
        free_set   = 1'b1;
        k_next     = k_last ? '0 : k + 1'b1;
        found_next = 1'b0;
      end
      gdg_pkg::S_MK: begin
        ram_raddr = k;
      end
      gdg_pkg::S_MK2: begin
        if (take_rv) begin
          found_next     = 1'b1;
          best_key_next  = key_rv;
          best_idx_next  = rv_idx;
          best_pair_next = rdata;
        end else if (take_fw) begin
          found_next     = 1'b1;
          best_key_next  = key_fw;
          best_idx_next  = fw_idx;
          best_pair_next = rdata;
        end
        if (k_last) begin
          k_next = '0;
          if (take_rv) begin
            start_idx_next = rv_idx;
            cur_idx_next   = rv_idx;
            cur_pair_next  = rdata;
          end else if (take_fw) begin
            start_idx_next = fw_idx;
            cur_idx_next   = fw_idx;
            cur_pair_next  = rdata;
          end else begin
            start_idx_next = best_idx;
            cur_idx_next   = best_idx;
            cur_pair_next  = best_pair;
          end
        end else begin
          k_next = k + 1'b1;
        end
      end
      gdg_pkg::S_WK: begin
        ram_raddr = k;
      end
      gdg_pkg::S_WK2: begin
        if (fw_m) begin
          nxt_idx_next  = fw_idx;
          nxt_pair_next = rdata;
        end else if (rv_m) begin
          nxt_idx_next  = rv_idx;
          nxt_pair_next = rdata;
        end else if (k_last) begin
          // No turn matches, so the walk stays on the current edge.
          nxt_idx_next  = cur_idx;
          nxt_pair_next = cur_pair;
        end else begin
          k_next = k + 1'b1;
        end
      end
      gdg_pkg::S_WHIT: begin
        k_next     = '0;
        found_next = 1'b0;
        if (!free[nxt_idx]) begin
          err_next = 1'b1;
        end else begin
          free_clr      = 1'b1;
          cur_idx_next  = nxt_idx;
          cur_pair_next = nxt_pair;
          if (nxt_idx == start_idx) begin
            faces_next = faces + 1'b1;
          end
        end
      end
      gdg_pkg::S_DONE: begin
        load_out = !result_valid || !result_stall;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    len       <= len_next;
    err       <= err_next;
    cprev     <= cprev_next;
    ccur      <= ccur_next;
    cfirst    <= cfirst_next;
    k         <= k_next;
    j         <= j_next;
    dup       <= dup_next;
    pk        <= pk_next;
    found     <= found_next;
    best_key  <= best_key_next;
    best_idx  <= best_idx_next;
    best_pair <= best_pair_next;
    start_idx <= start_idx_next;
    cur_idx   <= cur_idx_next;
    cur_pair  <= cur_pair_next;
    nxt_idx   <= nxt_idx_next;
    nxt_pair  <= nxt_pair_next;
    faces     <= faces_next;
    if (load_out) begin
      genus_value <= genus_v;
      face_count  <= faces;
      error_flag  <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= gdg_pkg::S_IDLE;
      free         <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      // The forward and reverse edge of a pair sit side by side.
      if (free_set) begin
        free[fw_idx +: 2] <= {2{!dup}};
      end
      if (free_clr) begin
        free[nxt_idx] <= 1'b0;
      end
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

### hw/rtl/gauss_diagram_genus_face_tracer.sv
// Top level of the Gauss diagram genus tracer: front end, command queue and back end.
//
// Input channel (item_valid / item_stall): one Gauss code element per transfer,
// an id, an over/under mark and a sign; last closes the code. Elements stream in
// at one per cycle while the four-entry command queue has room.
// Output channel (result_valid / result_stall): one result per code, holding the
// genus, the number of faces traced and an error flag.
// After the last element the back end writes the closing pairs, folds duplicate
// edges, then alternates start searches and walk steps over the pairs of the code;
// every step is a read through the single read port of the pair memory, which
// sets the pace. A code flagged as an error by the front end skips these steps
// and goes straight to the result.
// Reset clears the queue, the element counter, the free-edge bits and the
// result valid flag; the pair memory needs no clearing.
// While result_stall is high the result holds; the back end waits with the next
// code and the front end keeps loading elements until the queue is full.
module gauss_diagram_genus_face_tracer (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [gdg_pkg::ID_W-1:0]   crossing_id,
  input  logic                       is_over,
  input  logic                       crossing_sign,
  input  logic                       last,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [gdg_pkg::GEN_W-1:0]  genus_value,
  output logic [gdg_pkg::FACE_W-1:0] face_count,
  output logic                       error_flag
);

  logic          push;
  logic          full;
  logic          pop;
  logic          empty;
  gdg_pkg::cmd_t cmd;
  gdg_pkg::cmd_t head;

  gdg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .crossing_id  (crossing_id),
    .is_over      (is_over),
    .crossing_sign(crossing_sign),
    .last         (last),
    .push         (push),
    .cmd          (cmd),
    .full         (full)
  );

  gdg_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(cmd),
    .full     (full),
    .pop      (pop),
    .pop_data (head),
    .empty    (empty)
  );

  gdg_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .fifo_empty  (empty),
    .pop         (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .genus_value (genus_value),
    .face_count  (face_count),
    .error_flag  (error_flag)
  );

`ifndef NO_ASSERTIONS
  // The front end never pushes a command into a full queue.
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command pushed into full queue");

  // The back end never pops an empty queue.
  assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command popped from empty queue");

  // An error result always reports genus zero.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && error_flag) |-> (genus_value == '0))
    else $error("error result with nonzero genus");
`endif

endmodule

### tb/gauss_diagram_genus_face_tracer_test.sv
// Testbench for the Gauss diagram genus tracer: random codes checked against a genus predictor.
module gauss_diagram_genus_face_tracer_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [gdg_pkg::ID_W-1:0] id;
    logic                     over;
    logic                     sign;
    logic                     last;
  } element_t;

  typedef struct {
    logic [gdg_pkg::GEN_W-1:0]  genus;
    logic [gdg_pkg::FACE_W-1:0] faces;
    logic                       err;
  } genus_result_t;

  typedef struct {
    int fi, fs, ti, ts, dir;
  } arc_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [gdg_pkg::ID_W-1:0] crossing_id = '0;
  logic is_over = 1'b0;
  logic crossing_sign = 1'b0;
  logic last = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [gdg_pkg::GEN_W-1:0] genus_value;
  logic [gdg_pkg::FACE_W-1:0] face_count;
  logic error_flag;

  element_t      pending_elems[$];
  genus_result_t expected_genus[$];
  int            mismatches = 0;

  // Code collected so far from accepted transfers.
  int  code_ids[gdg_pkg::MAX_CODE_LENGTH];
  int  code_signs[gdg_pkg::MAX_CODE_LENGTH];
  int  code_len = 0;
  bit  code_overflow = 0;

  gauss_diagram_genus_face_tracer i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int arc_key(arc_t a);
    int va, vb;
    va = a.fi * 3 + a.fs + 1;
    vb = a.ti * 3 + a.ts + 1;
    return ((va * (gdg_pkg::MAX_CROSSINGS * 3 + 3)) + vb) * 2 + (a.dir > 0 ? 1 : 0);
  endfunction

  // Traces the faces of the collected code and returns the expected result.
  function automatic genus_result_t trace_genus();
    arc_t built[gdg_pkg::EDGE_CAP];
    arc_t uniq[gdg_pkg::EDGE_CAP];
    bit   free_arc[gdg_pkg::EDGE_CAP];
    arc_t fw, rv, cur, cand;
    genus_result_t r;
    int verts, nb, nu, faces, best, hit, skey, f, j;
    bit err, dup, found;
    verts = code_len / 2;
    err = code_overflow;
    nb = 0; nu = 0; faces = 0;
    r.genus = '0; r.faces = '0; r.err = 1'b1;
    for (int k = 0; k < code_len; k++)
      if (code_ids[k] >= verts || code_ids[k] >= gdg_pkg::MAX_CROSSINGS) err = 1;
    if (err) return r;
    for (int k = 0; k < code_len; k++) begin
      j = (k + 1) % code_len;
      fw = '{code_ids[k], code_signs[k], code_ids[j], code_signs[j], 1};
      rv = '{fw.ti, fw.ts, fw.fi, fw.fs, -1};
      for (int m = 0; m < 2; m++) begin
        cand = (m == 0) ? fw : rv;
        built[nb] = cand;
        nb++;
        dup = 0;
        for (int u = 0; u < nu; u++)
          if (arc_key(uniq[u]) == arc_key(cand)) dup = 1;
        if (!dup) begin
          uniq[nu] = cand;
          free_arc[nu] = 1;
          nu++;
        end
      end
    end
    forever begin
      best = -1;
      for (int u = 0; u < nu; u++)
        if (free_arc[u] && (best < 0 || arc_key(uniq[u]) < arc_key(uniq[best]))) best = u;
      if (best < 0) break;
      cur = uniq[best];
      skey = arc_key(cur);
      do begin
        // Turn at the head vertex; the first built edge that fits wins.
        found = 0;
        for (int b = 0; b < nb && !found; b++) begin
          if (cur.ts == 0) begin
            f = (cur.dir < 0) ? -1 : 1;
            if (built[b].fi == cur.ti && built[b].fs == f * built[b].dir) found = 1;
          end else begin
            f = (cur.ts > 0) ? -1 : 1;
            if (built[b].fi == cur.ti && built[b].fs == 0 && built[b].dir == f * cur.dir)
              found = 1;
          end
          if (found) cand = built[b];
        end
        if (found) cur = cand;
        hit = -1;
        for (int u = 0; u < nu; u++)
          if (arc_key(uniq[u]) == arc_key(cur)) hit = u;
        if (hit < 0 || !free_arc[hit]) begin
          err = 1;
          break;
        end
        free_arc[hit] = 0;
      end while (arc_key(cur) != skey);
      if (err) break;
      faces++;
    end
    r.faces = faces[gdg_pkg::FACE_W-1:0];
    r.err = err;
    if (!err && faces <= verts + 2) r.genus = gdg_pkg::GEN_W'((verts + 2 - faces) / 2);
    return r;
  endfunction

  task automatic absorb_element(element_t e);
    if (code_len < gdg_pkg::MAX_CODE_LENGTH) begin
      code_ids[code_len] = e.id;
      code_signs[code_len] = e.over ? 0 : (e.sign ? -1 : 1);
      code_len++;
    end else begin
      code_overflow = 1;
    end
    if (e.last) begin
      expected_genus.insert(expected_genus.size(), trace_genus());
      code_len = 0;
      code_overflow = 0;
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Stimulus helpers.
  task automatic push_code(int ids[$], bit overs[$], bit signs[$]);
    element_t e;
    foreach (ids[k]) begin
      e.id = ids[k];
      e.over = overs[k];
      e.sign = signs[k];
      e.last = (k == ids.size() - 1);
      pending_elems.insert(pending_elems.size(), e);
    end
  endtask

  // Each id below n appears twice, once over and once under.
  task automatic push_knot(int n);
    int ids[$];
    bit overs[$], signs[$], seen[int];
    for (int c = 0; c < n; c++) begin
      ids.insert(ids.size(), c);
      ids.insert(ids.size(), c);
    end
    ids.shuffle();
    foreach (ids[k]) begin
      if (!seen.exists(ids[k])) begin
        seen[ids[k]] = $urandom_range(0, 1);
        overs.insert(overs.size(), seen[ids[k]]);
      end else begin
        overs.insert(overs.size(), !seen[ids[k]]);
      end
      signs.insert(signs.size(), bit'($urandom_range(0, 1)));
    end
    push_code(ids, overs, signs);
  endtask

  task automatic push_noise(int len, int max_id);
    int ids[$];
    bit overs[$], signs[$];
    for (int k = 0; k < len; k++) begin
      ids.insert(ids.size(), int'($urandom_range(0, max_id)));
      overs.insert(overs.size(), bit'($urandom_range(0, 1)));
      signs.insert(signs.size(), bit'($urandom_range(0, 1)));
    end
    push_code(ids, overs, signs);
  endtask

  int in_gap = 0;
  int out_gap = 0;

  // The last part of the run goes without idling.
  function automatic bit quiet_phase();
    return pending_elems.size() < 150;
  endfunction

  // Driver: one nonblocking assignment per signal per edge.
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        absorb_element(pending_elems.pop_front());
      end
      if (!(item_valid && item_stall)) begin
        if (in_gap > 0) begin
          in_gap--;
          item_valid <= 1'b0;
        end else if (pending_elems.size() > 0 && !quiet_phase() &&
                     $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(1, 15) - 1;
          item_valid <= 1'b0;
        end else if (pending_elems.size() > 0) begin
          item_valid <= 1'b1;
          crossing_id <= pending_elems[0].id;
          is_over <= pending_elems[0].over;
          crossing_sign <= pending_elems[0].sign;
          last <= pending_elems[0].last;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and result-side stall bursts.
  always @(posedge clk) begin
    genus_result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_genus.size() == 0) begin
          report_mismatch("unexpected result, genus", genus_value, 0);
        end else begin
          want = expected_genus.pop_front();
          if (genus_value !== want.genus) report_mismatch("genus", genus_value, want.genus);
          if (face_count !== want.faces) report_mismatch("faces", face_count, want.faces);
          if (error_flag !== want.err) report_mismatch("error flag", error_flag, want.err);
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        result_stall <= 1'b1;
      end else if (!quiet_phase() && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(1, 15) - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  initial begin
    int big = 0;
    int r;
    // Directed: tiny codes, a single element, the largest ids and overlong codes.
    push_knot(1);
    push_code('{0}, '{1}, '{0});
    push_code('{31}, '{0}, '{1});
    push_code('{0, 0}, '{0, 0}, '{1, 0});
    push_code('{0, 1, 0, 1}, '{1, 0, 0, 1}, '{0, 1, 0, 1});
    push_knot(2);
    push_knot(3);
    push_noise(6, 2);
    push_knot(gdg_pkg::MAX_CROSSINGS);
    push_noise(gdg_pkg::MAX_CODE_LENGTH + 1, 31);
    push_noise(gdg_pkg::MAX_CODE_LENGTH + 6, 5);
    while (pending_elems.size() < 1850) begin
      r = $urandom_range(0, 99);
      if (r < 2 && big < 3) begin
        push_knot($urandom_range(16, gdg_pkg::MAX_CROSSINGS));
        big++;
      end else if (r < 70) begin
        push_knot($urandom_range(1, 6));
      end else if (r < 85) begin
        push_noise(2 * $urandom_range(1, 6), $urandom_range(0, 5));
      end else if (r < 97) begin
        push_noise($urandom_range(1, 12), 31);
      end else if (r < 98) begin
        push_noise($urandom_range(gdg_pkg::MAX_CODE_LENGTH + 1,
                                  gdg_pkg::MAX_CODE_LENGTH + 4), 31);
      end else begin
        push_code('{$urandom_range(0, 31)}, '{$urandom_range(0, 1)}, '{$urandom_range(0, 1)});
      end
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (pending_elems.size() != 0 || item_valid || expected_genus.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS gauss_diagram_genus_face_tracer");
    end else begin
      $display("FAIL gauss_diagram_genus_face_tracer");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("FAIL gauss_diagram_genus_face_tracer");
    $finish;
  end

endmodule
